// File: design/smtr_pkg.sv
// Package for the stacked message trace ring.
// Holds item codes, fixed limits and the command structs shared by the parser and the store.
package smtr_pkg;

	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_RX    = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [15:0] MIN_PACKET   = 16'd13;
	localparam logic [15:0] TRAILER      = 16'd4;
	localparam logic [7:0]  PING_MARK    = 8'hFF;
	localparam logic [16:0] LEN_SAT      = 17'd255;
	localparam logic [16:0] POS_MAX      = 17'h1FFFF;
	localparam logic [3:0]  HEADER_BYTES = 4'd8;
	localparam logic [5:0]  COL_CHANNEL  = 6'd0;
	localparam logic [5:0]  COL_LENGTH   = 6'd1;
	localparam logic [5:0]  COL_HEADER   = 6'd2;
	localparam logic [5:0]  COL_PAYLOAD  = 6'd10;

	typedef struct packed {
		logic       en;
		logic       dir;
		logic [7:0] row;
		logic [7:0] chan;
		logic [7:0] len;
		logic [63:0] hdr;
		logic [8:0] fill;
	} head_wr_t;

	typedef struct packed {
		logic       en;
		logic       dir;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] data;
	} pay_wr_t;

	typedef struct packed {
		logic       en;
		logic       ok;
		logic       dir;
		logic [7:0] row;
		logic [5:0] col;
	} rd_req_t;

endpackage

// File: design/smtr_if.sv
// Channel interfaces of the stacked message trace ring.
// Depends on nothing; one interface for items and one for results.
interface smtr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] channel_id;
	logic [15:0] packet_length;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       read_direction;
	logic [3:0] read_row;
	logic [5:0] read_column;
	modport source(output valid, kind, channel_id, packet_length, data_byte, last_byte,
		read_direction, read_row, read_column, input ready);
	modport sink(input valid, kind, channel_id, packet_length, data_byte, last_byte,
		read_direction, read_row, read_column, output ready);
endinterface

interface smtr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [3:0] tx_write_row;
	logic [3:0] rx_write_row;
	logic       message_stored;
	logic       message_filtered;
	logic       packet_rejected;
	modport source(output valid, read_data, tx_write_row, rx_write_row, message_stored,
		message_filtered, packet_rejected, input ready);
	modport sink(input valid, read_data, tx_write_row, rx_write_row, message_stored,
		message_filtered, packet_rejected, output ready);
endinterface

// File: design/smtr_parse.sv
// Packet parser: walks the stacked packet byte by byte and issues row writes and read requests.
// Holds ring write rows and row valid bits; uses smtr_pkg.
module smtr_parse #(
	parameter int TRACE_ROWS = 16,
	parameter int TRACE_COLUMNS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        kind,
	input  logic [7:0]        channel_id,
	input  logic [15:0]       packet_length,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              read_direction,
	input  logic [3:0]        read_row,
	input  logic [5:0]        read_column,
	output smtr_pkg::head_wr_t head_wr,
	output smtr_pkg::pay_wr_t  pay_wr,
	output smtr_pkg::rd_req_t  rd_req,
	output logic [3:0]        tx_row,
	output logic [3:0]        rx_row,
	output logic              stored,
	output logic              filtered,
	output logic              rejected
);
	import smtr_pkg::*;

	localparam int RW = $clog2(TRACE_ROWS);

	typedef enum logic [2:0] {
		PH_IDLE, PH_SEEK, PH_HEADER, PH_PAYLOAD, PH_DONE
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [16:0]       pos_q, pos_d;
	logic [17:0]       mend_q, mend_d;
	logic [3:0]        cnt_q, cnt_d;
	logic              dir_q, dir_d;
	logic [8:0]        fill_q, fill_d;
	logic [RW-1:0]     wrow_q [2];
	logic [RW-1:0]     wrow_d [2];
	logic [TRACE_ROWS-1:0] valid_q [2];
	logic [TRACE_ROWS-1:0] valid_d [2];
	logic [7:0]        hold_q [8];
	logic [7:0]        hold_d [8];

	logic [15:0] body_end;
	logic [RW-1:0] r;
	logic        ping;
	logic [15:0] pay;
	logic [17:0] msg_end;
	logic [16:0] mlen;
	logic [9:0]  full_fill;
	logic [8:0]  rrow_w;
	logic        commit;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		mend_d = mend_q;
		cnt_d = cnt_q;
		dir_d = dir_q;
		fill_d = fill_q;
		wrow_d = wrow_q;
		valid_d = valid_q;
		hold_d = hold_q;
		head_wr = '0;
		pay_wr = '0;
		stored = 1'b0;
		filtered = 1'b0;
		rejected = 1'b0;
		commit = 1'b0;
		body_end = packet_length - TRAILER;
		r = '0;
		ping = 1'b0;
		pay = '0;
		msg_end = '0;
		mlen = '0;
		full_fill = '0;
		if (accept) begin
			if (kind == KIND_CLEAR) begin
				phase_d = PH_IDLE;
				pos_d = '0;
				cnt_d = '0;
				mend_d = '0;
				wrow_d[0] = '0;
				wrow_d[1] = '0;
				valid_d[0] = '0;
				valid_d[1] = '0;
			end else if (kind != KIND_READ) begin
				if (phase_q == PH_IDLE) begin
					dir_d = kind[0];
					pos_d = '0;
					mend_d = 18'd1;
					cnt_d = '0;
					phase_d = (packet_length < MIN_PACKET) ? PH_DONE : PH_SEEK;
				end
				r = wrow_q[dir_d];
				if (packet_length < MIN_PACKET) begin
					phase_d = PH_DONE;
					rejected = last_byte;
				end else begin
					if (phase_d == PH_SEEK && {1'b0, pos_d} == mend_d) begin
						if ({1'b0, mend_d} + 19'd8 <= {3'b0, body_end}) begin
							phase_d = PH_HEADER;
							cnt_d = '0;
						end else begin
							phase_d = PH_DONE;
						end
					end
					if (phase_d == PH_HEADER) begin
						hold_d[cnt_d[2:0]] = data_byte;
						cnt_d = cnt_d + 4'd1;
						ping = (hold_d[0] == PING_MARK) || (hold_d[1] == PING_MARK);
						filtered = (cnt_d == 4'd2) && ping;
						if (cnt_d >= HEADER_BYTES) begin
							pay = {hold_d[6], hold_d[7]};
							msg_end = {1'b0, pos_d} + 18'd1 + {2'b0, pay};
							mlen = 17'd8 + {1'b0, pay};
							full_fill = 10'd10 + {1'b0, pay[8:0]};
							if (ping) begin
								mend_d = msg_end;
								phase_d = PH_SEEK;
							end else if (msg_end > {2'b0, body_end}) begin
								phase_d = PH_DONE;
							end else begin
								head_wr.en = 1'b1;
								head_wr.dir = dir_d;
								head_wr.row = 8'(r);
								head_wr.chan = channel_id;
								head_wr.len = (mlen > LEN_SAT) ? 8'hFF : mlen[7:0];
								head_wr.hdr = {hold_d[7], hold_d[6], hold_d[5], hold_d[4],
									hold_d[3], hold_d[2], hold_d[1], hold_d[0]};
								head_wr.fill = (pay[15:9] != '0 ||
									full_fill >= 10'(TRACE_COLUMNS)) ?
									9'(TRACE_COLUMNS) : full_fill[8:0];
								fill_d = 9'd10;
								valid_d[dir_d][r] = 1'b0;
								mend_d = msg_end;
								if (pay == '0) begin
									commit = 1'b1;
									phase_d = PH_SEEK;
								end else begin
									phase_d = PH_PAYLOAD;
								end
							end
						end
					end else if (phase_d == PH_PAYLOAD) begin
						if (fill_q < 9'(TRACE_COLUMNS)) begin
							pay_wr.en = 1'b1;
							pay_wr.dir = dir_d;
							pay_wr.row = 8'(r);
							pay_wr.col = fill_q[7:0];
							pay_wr.data = data_byte;
							fill_d = fill_q + 9'd1;
						end
						if ({1'b0, pos_d} + 18'd1 == mend_d) begin
							commit = 1'b1;
							phase_d = PH_SEEK;
						end
					end
				end
				if (commit) begin
					stored = 1'b1;
					valid_d[dir_d][r] = 1'b1;
					wrow_d[dir_d] = (32'(r) == TRACE_ROWS - 1) ? '0 : r + RW'(1);
				end
				if (pos_d < POS_MAX) begin
					pos_d = pos_d + 17'd1;
				end
				if (last_byte) begin
					phase_d = PH_IDLE;
					pos_d = '0;
					cnt_d = '0;
				end
			end
		end
	end

	assign rrow_w = {5'b0, read_row};
	assign rd_req.en = accept;
	assign rd_req.dir = read_direction;
	assign rd_req.row = rrow_w[7:0];
	assign rd_req.col = read_column;
	assign rd_req.ok = (kind == KIND_READ) && (rrow_w < 9'(TRACE_ROWS)) &&
		valid_q[read_direction][rrow_w[RW-1:0]];

	assign tx_row = 4'(wrow_d[0]);
	assign rx_row = 4'(wrow_d[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			mend_q <= '0;
			cnt_q <= '0;
			dir_q <= 1'b0;
			fill_q <= '0;
			wrow_q[0] <= '0;
			wrow_q[1] <= '0;
			valid_q[0] <= '0;
			valid_q[1] <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			mend_q <= mend_d;
			cnt_q <= cnt_d;
			dir_q <= dir_d;
			fill_q <= fill_d;
			wrow_q <= wrow_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
	end

endmodule

// File: design/smtr_store.sv
// Trace storage: a row header memory and a payload byte memory, both with registered reads.
// Takes write and read commands from smtr_parse; uses smtr_pkg.
module smtr_store #(
	parameter int TRACE_ROWS = 16,
	parameter int TRACE_COLUMNS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  smtr_pkg::head_wr_t head_wr,
	input  smtr_pkg::pay_wr_t  pay_wr,
	input  smtr_pkg::rd_req_t  rd_req,
	output logic [7:0]        read_data
);
	import smtr_pkg::*;

	localparam int RW = $clog2(TRACE_ROWS);
	localparam int CW = $clog2(TRACE_COLUMNS);
	localparam int HW = 8 + 8 + 64 + 9;

	logic [HW-1:0] head_mem [2**(RW+1)];
	logic [7:0]    pay_mem [2**(RW+1+CW)];
	logic [HW-1:0] head_s1;
	logic [7:0]    pay_s1;
	logic          ok_s1;
	logic [5:0]    col_s1;
	logic [8:0]    col_w;
	logic [8:0]    rcol_w;
	logic [7:0]    chan_s1, len_s1;
	logic [63:0]   hdr_s1;
	logic [8:0]    fill_s1;
	logic [5:0]    hidx;

	assign rcol_w = {3'b0, rd_req.col};

	always_ff @(posedge clk) begin
		if (head_wr.en) begin
			head_mem[{head_wr.dir, head_wr.row[RW-1:0]}] <=
				{head_wr.chan, head_wr.len, head_wr.hdr, head_wr.fill};
		end
		if (pay_wr.en) begin
			pay_mem[{pay_wr.dir, pay_wr.row[RW-1:0], pay_wr.col[CW-1:0]}] <= pay_wr.data;
		end
		if (rd_req.en) begin
			head_s1 <= head_mem[{rd_req.dir, rd_req.row[RW-1:0]}];
			pay_s1 <= pay_mem[{rd_req.dir, rd_req.row[RW-1:0], rcol_w[CW-1:0]}];
			col_s1 <= rd_req.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s1 <= 1'b0;
		end else if (rd_req.en) begin
			ok_s1 <= rd_req.ok;
		end
	end

	assign {chan_s1, len_s1, hdr_s1, fill_s1} = head_s1;
	assign col_w = {3'b0, col_s1};
	assign hidx = col_s1 - COL_HEADER;

	always_comb begin
		read_data = '0;
		if (ok_s1 && col_w < fill_s1 && col_w < 9'(TRACE_COLUMNS)) begin
			if (col_s1 == COL_CHANNEL) begin
				read_data = chan_s1;
			end else if (col_s1 == COL_LENGTH) begin
				read_data = len_s1;
			end else if (col_s1 < COL_PAYLOAD) begin
				read_data = hdr_s1[8*hidx[2:0] +: 8];
			end else begin
				read_data = pay_s1;
			end
		end
	end

endmodule

// File: design/stacked_message_trace_ring.sv
// Top level of the stacked message trace ring.
// Instantiates smtr_parse and smtr_store; uses smtr_pkg, smtr_in_if and smtr_out_if.
//
//   port     | direction | moves
//   items    | sink      | one packet byte, read or clear per transfer
//   results  | source    | one result per item, in item order
//
// An item is taken every cycle unless the output stalls; its result is registered in
// stage one and then in the output register. The header and payload memories are read
// in the accept cycle; their registered data go to the output register when it moves.
// A stalled output holds both stages; items are taken again once the output moves.
// Reset needs no clearing pass: row valid bits are flip-flops.
module stacked_message_trace_ring #(
	parameter int TRACE_ROWS = 16,
	parameter int TRACE_COLUMNS = 64
) (
	input logic clk,
	input logic arst_n,
	smtr_in_if.sink items,
	smtr_out_if.source results
);
	import smtr_pkg::*;

	head_wr_t   head_wr;
	pay_wr_t    pay_wr;
	rd_req_t    rd_req;
	logic       accept, move;
	logic [3:0] tx_row, rx_row;
	logic       stored, filtered, rejected;
	logic [7:0] read_data;
	logic       valid_s1;
	logic [3:0] tx_row_s1, rx_row_s1;
	logic       stored_s1, filtered_s1, rejected_s1;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic [3:0] tx_row_q, rx_row_q;
	logic       stored_q, filtered_q, rejected_q;

	assign move = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || move;
	assign accept = items.valid && items.ready;

	smtr_parse #(.TRACE_ROWS(TRACE_ROWS), .TRACE_COLUMNS(TRACE_COLUMNS)) u_parse (
		.clk(clk), .arst_n(arst_n), .accept(accept),
		.kind(items.kind), .channel_id(items.channel_id),
		.packet_length(items.packet_length), .data_byte(items.data_byte),
		.last_byte(items.last_byte), .read_direction(items.read_direction),
		.read_row(items.read_row), .read_column(items.read_column),
		.head_wr(head_wr), .pay_wr(pay_wr), .rd_req(rd_req),
		.tx_row(tx_row), .rx_row(rx_row),
		.stored(stored), .filtered(filtered), .rejected(rejected)
	);

	smtr_store #(.TRACE_ROWS(TRACE_ROWS), .TRACE_COLUMNS(TRACE_COLUMNS)) u_store (
		.clk(clk), .arst_n(arst_n), .head_wr(head_wr), .pay_wr(pay_wr),
		.rd_req(rd_req), .read_data(read_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_row_s1 <= tx_row;
			rx_row_s1 <= rx_row;
			stored_s1 <= stored;
			filtered_s1 <= filtered;
			rejected_s1 <= rejected;
		end
		if (move) begin
			read_data_q <= read_data;
			tx_row_q <= tx_row_s1;
			rx_row_q <= rx_row_s1;
			stored_q <= stored_s1;
			filtered_q <= filtered_s1;
			rejected_q <= rejected_s1;
		end
	end

	assign results.valid = out_valid_q;
	assign results.read_data = read_data_q;
	assign results.tx_write_row = tx_row_q;
	assign results.rx_write_row = rx_row_q;
	assign results.message_stored = stored_q;
	assign results.message_filtered = filtered_q;
	assign results.packet_rejected = rejected_q;

endmodule

// File: design/smtr_check.sv
// Port checker for the stacked message trace ring, with its bind statement.
// Depends only on the top level's ports.
module smtr_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       stored,
	input logic       filtered,
	input logic       rejected
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result withdrawn before its transfer.");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({stored, filtered, rejected}) <= 1)
		else $error("More than one event flag on one result.");

	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 8'd0 |-> !stored && !filtered && !rejected)
		else $error("Read data on a packet byte result.");

	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("Result offered during reset.");

endmodule

bind stacked_message_trace_ring smtr_check u_check (
	.clk(clk), .arst_n(arst_n), .out_valid(results.valid), .out_ready(results.ready),
	.read_data(results.read_data), .stored(results.message_stored),
	.filtered(results.message_filtered), .rejected(results.packet_rejected)
);
